// ----- sv/hbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hbd_pkg;

	localparam int HBD_TAPS   = 39;
	localparam int HBD_NCOEF  = 20;
	localparam int HBD_CIDX_W = 5;
	localparam int HBD_COEF_W = 16;
	localparam int HBD_DIG_W  = 4;
	localparam int HBD_NDIG   = HBD_COEF_W / HBD_DIG_W;

	// Left half of the symmetric table, the centre tap last.
	localparam logic signed [HBD_COEF_W-1:0] HBD_COEF [HBD_NCOEF] = '{
		-16'sd1, 16'sd0, 16'sd2, 16'sd0, -16'sd10, 16'sd0, 16'sd35, 16'sd0,
		-16'sd103, 16'sd0, 16'sd266, 16'sd0, -16'sd616, 16'sd0, 16'sd1332,
		16'sd0, -16'sd2960, 16'sd0, 16'sd10246, 16'sd16384
	};

	typedef struct packed {
		logic signed [15:0] sample_left;
		logic signed [15:0] sample_right;
	} hbd_in_t;

	typedef struct packed {
		logic               out_valid;
		logic signed [15:0] out_left;
		logic signed [15:0] out_right;
		logic signed [31:0] error_total;
		logic signed [31:0] overflow_total;
	} hbd_out_t;

	typedef struct packed {
		logic                 clr;
		logic                 mul_en;
		logic                 first;
		logic                 acc_en;
		logic                 neg;
		logic                 casc;
		logic [HBD_DIG_W-1:0] dig;
	} hbd_mac_ctl_t;

	typedef struct packed {
		logic signed [15:0] smp;
		logic [14:0]        frac;
		logic [16:0]        ovf;
	} hbd_mac_res_t;

	function automatic logic signed [HBD_COEF_W-1:0] hbd_coef(input logic [HBD_CIDX_W-1:0] k);
		logic signed [HBD_COEF_W-1:0] c;
		c = '0;
		if (32'(k) < HBD_NCOEF) begin
			c = HBD_COEF[k];
		end
		return c;
	endfunction

	function automatic logic signed [15:0] hbd_sat16(input logic signed [16:0] v);
		logic signed [15:0] r;
		if (v > 17'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -17'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- sv/hbd_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 39
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

// ----- sv/hbd_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hbd_mac import hbd_pkg::*; (
	input  wire logic               clk,
	input  wire hbd_mac_ctl_t       ctl,
	input  wire logic signed [16:0] x,
	output hbd_mac_res_t            res
);

	logic signed [31:0] prod_q;
	logic signed [31:0] acc_q;
	logic signed [21:0] part;
	logic signed [31:0] sum;
	logic signed [15:0] clamp;
	logic signed [16:0] sh;
	logic signed [16:0] ovf_mag;

	// One coefficient digit per cycle, most significant digit first.
	assign part = x * $signed({1'b0, ctl.dig});

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			if (ctl.first) begin
				prod_q <= 32'(part);
			end else begin
				prod_q <= (prod_q <<< HBD_DIG_W) + 32'(part);
			end
		end
	end

	always_comb begin
		sum   = ctl.neg ? acc_q - prod_q : acc_q + prod_q;
		clamp = hbd_sat16(sum[31:15]);
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			if (ctl.casc) begin
				acc_q <= {clamp[15], clamp, 15'd0};
			end else begin
				acc_q <= sum;
			end
		end
	end

	always_comb begin
		sh      = acc_q[31:15];
		ovf_mag = '0;
		if (sh > 17'sd32767) begin
			ovf_mag = sh - 17'sd32767;
		end else if (sh < -17'sd32768) begin
			ovf_mag = -17'sd32768 - sh;
		end
		res.smp  = hbd_sat16(sh);
		res.frac = acc_q[14:0];
		res.ovf  = ovf_mag;
	end

endmodule

`default_nettype wire

// ----- sv/halfband_fir_stereo_decimator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Stereo half-band decimator by two with a folded 39-tap FIR per channel.
// Input channel in_valid/in_ready carries one left/right sample pair per beat;
// result channel res_valid/res_ready returns exactly one beat for every input
// beat. Every second input beat, starting with the first after reset, yields
// filtered samples with out_valid set; the others return zero samples with
// out_valid clear and the running error and overflow totals unchanged.
// A retained beat passes from acceptance until its result is shown and in_ready
// returns through the read state, eleven products through the radix-16
// digit-serial multiplier (one per channel, both channels side by side), the
// final accumulate and the result state. A discarded beat goes straight from
// acceptance to the result state. The next beat is taken in the idle state.
// The cascade clamp is to be written through cfg_we/cfg_wdata while the block is idle; the block does not enforce it.
// Reset clears the write pointer, phase, totals and the per-slot valid bits,
// so unwritten history reads as zero at once; there is no clearing pass.
// The result register decouples the two sides: the next input beat is taken
// while a result waits, and a further result then holds in its final state
// until the receiver takes the earlier one.
module halfband_fir_stereo_decimator import hbd_pkg::*; #(
	parameter int TAPS = HBD_TAPS
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire hbd_in_t  in_data,
	output logic          res_valid,
	input  wire logic     res_ready,
	output hbd_out_t      res_data,
	input  wire logic     cfg_we,
	input  wire logic     cfg_wdata
);

	localparam int ADDR_W    = $clog2(TAPS);
	localparam int CENTRE    = (TAPS - 1) / 2;
	localparam int NSTEP     = (CENTRE + 1) / 2 + 1;
	localparam int STEP_W    = $clog2(NSTEP);
	localparam int DIG_CNT_W = $clog2(HBD_NDIG);

	localparam logic [ADDR_W-1:0]    LAST_SLOT = ADDR_W'(TAPS - 1);
	localparam logic [STEP_W-1:0]    LAST_STEP = STEP_W'(NSTEP - 1);
	localparam logic [DIG_CNT_W-1:0] LAST_DIG  = DIG_CNT_W'(HBD_NDIG - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	// Slot of tap k, counting back from the newest sample around the ring.
	function automatic logic [ADDR_W-1:0] tap_slot(input logic [ADDR_W-1:0] newest,
			input logic [ADDR_W-1:0] k);
		logic [ADDR_W:0] wrapped;
		logic [ADDR_W-1:0] slot;
		wrapped = {1'b0, newest} + (ADDR_W + 1)'(TAPS) - {1'b0, k};
		if (newest >= k) begin
			slot = newest - k;
		end else begin
			slot = wrapped[ADDR_W-1:0];
		end
		return slot;
	endfunction

	// Step 0 is the centre tap; step s is the pair at distance 2(s-1).
	function automatic logic [ADDR_W-1:0] step_tap(input logic [STEP_W-1:0] s);
		logic [ADDR_W-1:0] k;
		k = ADDR_W'(s) - 1'b1;
		if (s == '0) begin
			k = ADDR_W'(CENTRE);
		end else begin
			k = k << 1;
		end
		return k;
	endfunction

	logic [2:0]           state_q;
	logic [STEP_W-1:0]    step_q;
	logic [DIG_CNT_W-1:0] dig_q;
	logic [ADDR_W-1:0]    wr_ptr_q;
	logic [ADDR_W-1:0]    newest_q;
	logic                 skip_q;
	logic                 keep_q;
	logic                 casc_q;
	logic [TAPS-1:0]      vld_q;
	logic                 vlda_q;
	logic                 vldb_q;
	logic [HBD_COEF_W-1:0] cshift_q;
	logic                 cneg_q;
	logic                 pneg_q;
	logic [31:0]          err_sum_q;
	logic [31:0]          ovf_sum_q;
	logic                 res_vld_q;
	hbd_out_t             res_q;

	logic                 in_go;
	logic                 fin_go;
	logic                 rd_en;
	logic [STEP_W-1:0]    rd_step;
	logic [ADDR_W-1:0]    rd_k;
	logic [ADDR_W-1:0]    rd_kb;
	logic [ADDR_W-1:0]    raddr_a;
	logic [ADDR_W-1:0]    raddr_b;
	logic signed [HBD_COEF_W-1:0] rd_coef;
	logic [HBD_COEF_W-1:0] rd_mag;
	logic [31:0]          q_a;
	logic [31:0]          q_b;
	logic signed [15:0]   a_l;
	logic signed [15:0]   a_r;
	logic signed [15:0]   b_l;
	logic signed [15:0]   b_r;
	logic signed [16:0]   x_l;
	logic signed [16:0]   x_r;
	logic                 centre;
	hbd_mac_ctl_t         mac_ctl;
	hbd_mac_res_t         res_l;
	hbd_mac_res_t         res_r;
	logic [31:0]          err_add;
	logic [31:0]          ovf_add;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_go     = in_valid && in_ready;
	assign fin_go    = (state_q == ST_FIN) && (!res_vld_q || res_ready);
	assign res_valid = res_vld_q;
	assign res_data  = res_q;

	// The read for the next product is issued in the last digit cycle of the
	// current one, so the RAM output holds steady for a whole product.
	always_comb begin
		rd_en   = (state_q == ST_RD) ||
			((state_q == ST_MUL) && (dig_q == LAST_DIG) && (step_q != LAST_STEP));
		rd_step = (state_q == ST_RD) ? '0 : step_q + 1'b1;
		rd_k    = step_tap(rd_step);
		rd_kb   = (rd_step == '0) ? rd_k : LAST_SLOT - rd_k;
		raddr_a = tap_slot(newest_q, rd_k);
		raddr_b = tap_slot(newest_q, rd_kb);
		rd_coef = hbd_coef(rd_k[HBD_CIDX_W-1:0]);
		rd_mag  = rd_coef[HBD_COEF_W-1] ? HBD_COEF_W'(-rd_coef) : rd_coef;
	end

	hbd_ram #(
		.WIDTH(32),
		.DEPTH(TAPS)
	) u_hist (
		.clk    (clk),
		.we     (in_go),
		.waddr  (wr_ptr_q),
		.wdata  ({in_data.sample_left, in_data.sample_right}),
		.re     (rd_en),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(q_a),
		.rdata_b(q_b)
	);

	// Slots never written since reset read as zero; the centre tap has no partner.
	always_comb begin
		centre = (step_q == '0);
		a_l    = vlda_q ? $signed(q_a[31:16]) : 16'sd0;
		a_r    = vlda_q ? $signed(q_a[15:0])  : 16'sd0;
		b_l    = (vldb_q && !centre) ? $signed(q_b[31:16]) : 16'sd0;
		b_r    = (vldb_q && !centre) ? $signed(q_b[15:0])  : 16'sd0;
		x_l    = {a_l[15], a_l} + {b_l[15], b_l};
		x_r    = {a_r[15], a_r} + {b_r[15], b_r};
	end

	// The product finished in the previous step is added in the first digit
	// cycle of the next one, or in the final accumulate cycle.
	always_comb begin
		mac_ctl.clr    = (state_q == ST_RD);
		mac_ctl.mul_en = (state_q == ST_MUL);
		mac_ctl.first  = (dig_q == '0);
		mac_ctl.acc_en = ((state_q == ST_MUL) && (dig_q == '0) && (step_q != '0)) ||
			(state_q == ST_ACC);
		mac_ctl.neg    = pneg_q;
		mac_ctl.casc   = casc_q;
		mac_ctl.dig    = cshift_q[HBD_COEF_W-1 -: HBD_DIG_W];
	end

	hbd_mac u_mac_l (
		.clk(clk),
		.ctl(mac_ctl),
		.x  (x_l),
		.res(res_l)
	);

	hbd_mac u_mac_r (
		.clk(clk),
		.ctl(mac_ctl),
		.x  (x_r),
		.res(res_r)
	);

	assign err_add = 32'(res_l.frac) + 32'(res_r.frac);
	assign ovf_add = 32'(res_l.ovf) + 32'(res_r.ovf);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			dig_q     <= '0;
			wr_ptr_q  <= '0;
			newest_q  <= '0;
			skip_q    <= 1'b0;
			keep_q    <= 1'b0;
			casc_q    <= 1'b0;
			vld_q     <= '0;
			err_sum_q <= '0;
			ovf_sum_q <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				casc_q <= cfg_wdata;
			end
			if (fin_go) begin
				res_vld_q <= 1'b1;
			end else if (res_ready) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_go) begin
						vld_q[wr_ptr_q] <= 1'b1;
						newest_q        <= wr_ptr_q;
						wr_ptr_q        <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
						skip_q          <= !skip_q;
						keep_q          <= !skip_q;
						state_q         <= skip_q ? ST_FIN : ST_RD;
					end
				end
				ST_RD: begin
					step_q  <= '0;
					dig_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					dig_q <= dig_q + 1'b1;
					if (dig_q == LAST_DIG) begin
						if (step_q == LAST_STEP) begin
							state_q <= ST_ACC;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				ST_ACC: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						if (keep_q) begin
							err_sum_q <= err_sum_q + err_add;
							ovf_sum_q <= ovf_sum_q + ovf_add;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Coefficient digit shifter and tap valid flags follow the RAM reads.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			cshift_q <= rd_mag;
			cneg_q   <= rd_coef[HBD_COEF_W-1];
			vlda_q   <= vld_q[raddr_a];
			vldb_q   <= vld_q[raddr_b];
		end else if (state_q == ST_MUL) begin
			cshift_q <= cshift_q << HBD_DIG_W;
		end
		if ((state_q == ST_MUL) && (dig_q == LAST_DIG)) begin
			pneg_q <= cneg_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			if (keep_q) begin
				res_q.out_valid      <= 1'b1;
				res_q.out_left       <= res_l.smp;
				res_q.out_right      <= res_r.smp;
				res_q.error_total    <= err_sum_q + err_add;
				res_q.overflow_total <= ovf_sum_q + ovf_add;
			end else begin
				res_q.out_valid      <= 1'b0;
				res_q.out_left       <= '0;
				res_q.out_right      <= '0;
				res_q.error_total    <= err_sum_q;
				res_q.overflow_total <= ovf_sum_q;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/hbd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hbd_checker import hbd_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_ready,
	input wire hbd_in_t  in_data,
	input wire logic     res_valid,
	input wire logic     res_ready,
	input wire hbd_out_t res_data
);

	logic expect_keep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_keep_q <= 1'b1;
		end else if (res_valid && res_ready) begin
			expect_keep_q <= !expect_keep_q;
		end
	end

	// A stalled result beat holds its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result beat changed while stalled");

	// The block works on one input beat at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !$isunknown(in_data) |=> !in_ready)
		else $error("input taken while busy");

	// Retained and discarded result beats alternate, starting with retained.
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |-> res_data.out_valid == expect_keep_q)
		else $error("decimation phase out of order");

	// A discarded beat carries zero samples.
	a_discard_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.out_valid |->
			res_data.out_left == 16'sd0 && res_data.out_right == 16'sd0)
		else $error("discarded beat with nonzero samples");

endmodule

bind halfband_fir_stereo_decimator hbd_checker u_hbd_checker (.*);

`default_nettype wire
